>>> src/graph_traversal_bfs_dfs_assert.svh
// Assertion macros shared by the graph traversal block
`ifndef GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH
`define GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH
`ifndef SYNTHESIS
`define GTB_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("graph traversal invariant violated");
`define GTB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graph traversal implication violated");
`else
`define GTB_ASSERT_ALWAYS(lbl, cond)
`define GTB_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> src/gtb_pkg.sv
// Types and constants of the graph traversal block
`timescale 1ns / 1ps
package gtb_pkg;
	localparam int NODE_ID_W   = 4;
	localparam int ROW_IN_W    = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic ORDER_BFS = 1'b0;
	localparam logic ORDER_DFS = 1'b1;

	// register index, taken from paddr above the byte offset
	localparam logic REG_TRAVERSAL_ORDER = 1'b0;

	typedef struct packed {
		logic                 req_type;
		logic [NODE_ID_W-1:0] node_id;
		logic [ROW_IN_W-1:0]  neighbor_bits;
	} gtb_in_t;

	typedef struct packed {
		logic [NODE_ID_W-1:0] visited_node;
		logic                 last_visit;
	} gtb_out_t;

	typedef struct packed {
		logic load;        // store an adjacency row
		logic start_bfs;   // seed queue with start node
		logic start_dfs;   // seed stack top, record start visit
		logic q_read;      // read queue head, advance head
		logic visit_q;     // record dequeued node, read its row
		logic enq;         // enqueue lowest unvisited neighbor
		logic adj_rd_top;  // read row of stack top node
		logic push;        // record neighbor, push it onto stack
		logic pop;         // drop stack top, read the entry below
		logic pop_load;    // reload stack top from memory
		logic flush;       // emit pending visit as final item
	} gtb_cmd_t;

	typedef struct packed {
		logic node_ok;
		logic req_start;
		logic q_empty;
		logic bfs_cand;
		logic dfs_cand;
		logic depth_one;
		logic emit_ok;
		logic out_free;
		logic cnt_last;
	} gtb_sts_t;
endpackage

>>> src/gtb_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module gtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> src/gtb_ctrl.sv
// Sequencer of the graph traversal block
`timescale 1ns / 1ps
module gtb_ctrl import gtb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     order,
	input  gtb_sts_t sts,
	output gtb_cmd_t cmd,
	output logic     idle
);
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_B_POP   = 3'd1;
	localparam logic [2:0] S_B_VISIT = 3'd2;
	localparam logic [2:0] S_B_SCAN  = 3'd3;
	localparam logic [2:0] S_D_READ  = 3'd4;
	localparam logic [2:0] S_D_SCAN  = 3'd5;
	localparam logic [2:0] S_D_POP   = 3'd6;
	localparam logic [2:0] S_FLUSH   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && sts.node_ok) begin
					if (sts.req_start == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else if (order == ORDER_DFS) begin
						cmd.start_dfs = 1'b1;
						state_nxt     = S_D_READ;
					end else begin
						cmd.start_bfs = 1'b1;
						state_nxt     = S_B_POP;
					end
				end
			end
			S_B_POP: begin
				if (sts.q_empty) begin
					state_nxt = S_FLUSH;
				end else begin
					cmd.q_read = 1'b1;
					state_nxt  = S_B_VISIT;
				end
			end
			S_B_VISIT: begin
				// hold until the previous visit can move to the output register
				if (sts.emit_ok) begin
					cmd.visit_q = 1'b1;
					state_nxt   = sts.cnt_last ? S_FLUSH : S_B_SCAN;
				end
			end
			S_B_SCAN: begin
				if (sts.bfs_cand) begin
					cmd.enq = 1'b1;
				end else begin
					state_nxt = S_B_POP;
				end
			end
			S_D_READ: begin
				cmd.adj_rd_top = 1'b1;
				state_nxt      = S_D_SCAN;
			end
			S_D_SCAN: begin
				if (sts.dfs_cand) begin
					if (sts.emit_ok) begin
						cmd.push  = 1'b1;
						state_nxt = sts.cnt_last ? S_FLUSH : S_D_READ;
					end
				end else begin
					cmd.pop   = 1'b1;
					state_nxt = sts.depth_one ? S_FLUSH : S_D_POP;
				end
			end
			S_D_POP: begin
				cmd.pop_load = 1'b1;
				state_nxt    = S_D_READ;
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign idle = (state_q == S_IDLE);
endmodule

>>> src/gtb_dp.sv
// Datapath of the graph traversal block: rows, queue, stack, marks, output register
`timescale 1ns / 1ps
`include "graph_traversal_bfs_dfs_assert.svh"
module gtb_dp import gtb_pkg::*; #(
	parameter int NODE_COUNT = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  gtb_in_t  in_data,
	input  gtb_cmd_t cmd,
	output gtb_sts_t sts,
	output logic     out_valid,
	input  logic     out_stall,
	output gtb_out_t out_data
);
	localparam int NW = $clog2(NODE_COUNT);
	localparam int PW = NW + 1;
	localparam int SW = NW + PW;

	logic [NODE_COUNT-1:0] adj_vld_q;
	logic                  adj_hit_q;
	logic                  adj_re;
	logic [NW-1:0]         adj_raddr;
	logic [NODE_COUNT-1:0] adj_rdata;
	logic [NODE_COUNT-1:0] row;

	logic [NW-1:0]         q_rdata;
	logic                  q_we;
	logic [NW-1:0]         q_waddr;
	logic [NW-1:0]         q_wdata;

	logic [SW-1:0]         stk_rdata;
	logic                  stk_re;
	logic [PW-1:0]         depth_m1;
	logic [PW-1:0]         depth_m2;

	logic [PW-1:0]         head_q;
	logic [PW-1:0]         tail_q;
	logic [PW-1:0]         depth_q;
	logic [NW-1:0]         tnode_q;
	logic [PW-1:0]         tres_q;
	logic [NODE_COUNT-1:0] visited_q;
	logic [CNT_W-1:0]      count_q;
	logic [NW-1:0]         pend_q;
	logic                  pend_vld_q;
	logic                  out_vld_q;
	gtb_out_t              out_q;

	logic [NW-1:0]         start_node;
	logic [NODE_COUNT-1:0] res_mask;
	logic [NODE_COUNT-1:0] cand_b;
	logic [NODE_COUNT-1:0] cand_d;
	logic [NW-1:0]         low_b;
	logic [NW-1:0]         low_d;
	logic                  visit;
	logic [NW-1:0]         visit_node;
	logic                  emit;
	logic                  out_free;

	function automatic logic [NW-1:0] lowest(input logic [NODE_COUNT-1:0] v);
		logic [NW-1:0] r;
		r = '0;
		for (int b = NODE_COUNT - 1; b >= 0; b--) begin
			if (v[b]) begin
				r = NW'(b);
			end
		end
		return r;
	endfunction

	assign start_node = NW'(in_data.node_id);

	// adjacency rows; an entry never loaded reads as no edges
	gtb_ram #(.WIDTH(NODE_COUNT), .DEPTH(NODE_COUNT)) u_adj (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(start_node),
		.wdata(NODE_COUNT'(in_data.neighbor_bits)),
		.re   (adj_re),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	assign adj_re    = cmd.visit_q | cmd.adj_rd_top;
	assign adj_raddr = cmd.visit_q ? q_rdata : tnode_q;
	assign row       = adj_hit_q ? adj_rdata : '0;

	gtb_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.re   (cmd.q_read),
		.raddr(head_q[NW-1:0]),
		.rdata(q_rdata)
	);

	assign q_we    = cmd.start_bfs | cmd.enq;
	assign q_waddr = cmd.start_bfs ? '0 : tail_q[NW-1:0];
	assign q_wdata = cmd.start_bfs ? start_node : low_b;

	// entries below the top; the top node and resume index live in tnode_q/tres_q
	assign depth_m1 = depth_q - PW'(1);
	assign depth_m2 = depth_q - PW'(2);
	assign stk_re   = cmd.pop & (depth_q > PW'(1));

	gtb_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(depth_m1[NW-1:0]),
		.wdata({tnode_q, PW'(low_d) + PW'(1)}),
		.re   (stk_re),
		.raddr(depth_m2[NW-1:0]),
		.rdata(stk_rdata)
	);

	always_comb begin
		for (int b = 0; b < NODE_COUNT; b++) begin
			res_mask[b] = (PW'(b) >= tres_q);
		end
	end

	assign cand_b = row & ~visited_q;
	assign cand_d = row & ~visited_q & res_mask;
	assign low_b  = lowest(cand_b);
	assign low_d  = lowest(cand_d);

	assign visit      = cmd.visit_q | cmd.push | cmd.start_dfs;
	assign visit_node = cmd.visit_q ? q_rdata : (cmd.push ? low_d : start_node);
	assign emit       = (visit & pend_vld_q) | cmd.flush;
	assign out_free   = ~out_vld_q | ~out_stall;

	always_comb begin
		sts           = '0;
		sts.node_ok   = (32'(in_data.node_id) < NODE_COUNT);
		sts.req_start = in_data.req_type;
		sts.q_empty   = (head_q == tail_q);
		sts.bfs_cand  = (|cand_b) & (tail_q < PW'(NODE_COUNT));
		sts.dfs_cand  = (|cand_d) & (depth_q < PW'(NODE_COUNT));
		sts.depth_one = (depth_q == PW'(1));
		sts.emit_ok   = ~pend_vld_q | out_free;
		sts.out_free  = out_free;
		sts.cnt_last  = (count_q == CNT_W'(MAX_RESULTS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			depth_q    <= '0;
			visited_q  <= '0;
			count_q    <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				adj_vld_q[start_node] <= 1'b1;
			end
			if (cmd.start_bfs) begin
				head_q     <= '0;
				tail_q     <= PW'(1);
				count_q    <= '0;
				pend_vld_q <= 1'b0;
				visited_q  <= NODE_COUNT'(1) << start_node;
			end else if (cmd.start_dfs) begin
				depth_q   <= PW'(1);
				visited_q <= NODE_COUNT'(1) << start_node;
			end
			if (cmd.q_read) begin
				head_q <= head_q + PW'(1);
			end
			if (cmd.enq) begin
				tail_q             <= tail_q + PW'(1);
				visited_q[low_b]   <= 1'b1;
			end
			if (cmd.push) begin
				depth_q          <= depth_q + PW'(1);
				visited_q[low_d] <= 1'b1;
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
			end
			if (visit) begin
				pend_vld_q <= 1'b1;
				count_q    <= cmd.start_dfs ? CNT_W'(1) : count_q + CNT_W'(1);
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adj_re) begin
			adj_hit_q <= adj_vld_q[adj_raddr];
		end
		if (cmd.start_dfs || cmd.push) begin
			tnode_q <= visit_node;
			tres_q  <= '0;
		end else if (cmd.pop_load) begin
			{tnode_q, tres_q} <= stk_rdata;
		end
		if (visit) begin
			pend_q <= visit_node;
		end
		if (emit) begin
			out_q.visited_node <= NODE_ID_W'(pend_q);
			out_q.last_visit   <= cmd.flush;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`GTB_ASSERT_ALWAYS(a_head_le_tail, head_q <= tail_q)
	`GTB_ASSERT_ALWAYS(a_depth_bound, depth_q <= PW'(NODE_COUNT))
	`GTB_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(MAX_RESULTS))
	`GTB_ASSERT_IMPL(a_emit_room, emit, out_free)
endmodule

>>> src/graph_traversal_bfs_dfs.sv
// Breadth-first / depth-first traversal over a stored adjacency matrix: top level
// A load item stores one row. A start item walks one step per cycle in the sequencer while
// the output has room: breadth-first per dequeued node and queued neighbor, depth-first per
// visit and backtrack, then a flush. The first result leaves when the second visit is found.
// Input is stalled for the whole walk; an adjacency row is read per visited node, and in
// depth-first per backtrack. Reset clears all rows to no edges, the marks and the order register.
`timescale 1ns / 1ps
module graph_traversal_bfs_dfs import gtb_pkg::*; #(
	parameter int NODE_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gtb_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output gtb_out_t           out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	gtb_cmd_t cmd;
	gtb_sts_t sts;
	logic     idle;
	logic     order_q;
	logic     reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_TRAVERSAL_ORDER);
	assign prdata  = reg_sel ? {{(PDATA_W-1){1'b0}}, order_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_BFS;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			order_q <= pwdata[0];
		end
	end

	assign in_stall = ~idle;

	gtb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.order   (order_q),
		.sts     (sts),
		.cmd     (cmd),
		.idle    (idle)
	);

	gtb_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);
endmodule

>>> test/graph_traversal_bfs_dfs_tb.sv
// Self-checking testbench for the breadth-first / depth-first graph traversal block
`timescale 1ns / 1ps
module graph_traversal_bfs_dfs_tb import gtb_pkg::*; ();

	localparam int NODES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES = 300;
	localparam logic [PADDR_W-1:0] ORDER_ADDR = PADDR_W'({REG_TRAVERSAL_ORDER, 2'b00});

	typedef struct packed {
		gtb_in_t              item;
		logic                 typed;
		logic [NODE_ID_W-1:0] want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	gtb_in_t            in_data;
	logic               out_valid;
	logic               out_stall;
	gtb_out_t           out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// model of the block: stored rows and the order register
	logic [ROW_IN_W-1:0] adj_rows [NODES];
	logic                walk_order;
	gtb_out_t            visit_queue [$];
	gtb_out_t            visit_want;

	int          mismatches = 0;
	int          visits_taken = 0;
	int          burst_left = 0;
	int unsigned cycle_count = 0;
	logic        pressure_done = 1'b0;

	// typed rows: a single final visit, readable straight off the graph
	stim_row_t directed_rows [21] = '{
		{REQ_START, 4'd0,  16'h0000, 1'b1, 4'd0},
		{REQ_START, 4'd15, 16'hFFFF, 1'b1, 4'd15},
		{REQ_LOAD,  4'd0,  16'hFFFF, 1'b0, 4'd0},
		{REQ_START, 4'd0,  16'h0000, 1'b0, 4'd0},
		{REQ_LOAD,  4'd0,  16'h0000, 1'b0, 4'd0},
		{REQ_LOAD,  4'd15, 16'hFFFF, 1'b0, 4'd0},
		{REQ_START, 4'd15, 16'h5A5A, 1'b0, 4'd0},
		{REQ_LOAD,  4'd1,  16'h0004, 1'b0, 4'd0},
		{REQ_LOAD,  4'd2,  16'h0008, 1'b0, 4'd0},
		{REQ_LOAD,  4'd3,  16'h0002, 1'b0, 4'd0},
		{REQ_LOAD,  4'd0,  16'h000A, 1'b0, 4'd0},
		{REQ_START, 4'd0,  16'h0000, 1'b0, 4'd0},
		{REQ_START, 4'd3,  16'hFFFF, 1'b0, 4'd0},
		{REQ_LOAD,  4'd15, 16'h8000, 1'b0, 4'd0},
		{REQ_START, 4'd15, 16'h0000, 1'b1, 4'd15},
		{REQ_LOAD,  4'd7,  16'h5555, 1'b0, 4'd0},
		{REQ_LOAD,  4'd8,  16'hAAAA, 1'b0, 4'd0},
		{REQ_START, 4'd7,  16'h0000, 1'b0, 4'd0},
		{REQ_START, 4'd8,  16'h0000, 1'b0, 4'd0},
		{REQ_LOAD,  4'd7,  16'h0000, 1'b0, 4'd0},
		{REQ_LOAD,  4'd8,  16'h0000, 1'b0, 4'd0}
	};

	graph_traversal_bfs_dfs #(
		.NODE_COUNT(NODES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	task automatic flag_mismatch(input string what);
		if (mismatches < 10) begin
			$display("mismatch: %s", what);
		end
		mismatches++;
	endtask

	// expected visit sequence of one walk from start, pushed in visit order
	function automatic void predict_walk(input logic [NODE_ID_W-1:0] start);
		logic [NODES-1:0]     marks;
		logic [NODE_ID_W-1:0] fifo [NODES];
		logic [NODE_ID_W-1:0] stk_node [NODES];
		int                   stk_resume [NODES];
		logic [NODE_ID_W-1:0] hits [MAX_RESULTS];
		logic [NODE_ID_W-1:0] cur;
		gtb_out_t             r;
		int                   head, tail, depth, top, cnt, i;
		marks = '0;
		cnt = 0;
		if (walk_order == ORDER_BFS) begin
			head = 0;
			tail = 1;
			fifo[0] = start;
			marks[start] = 1'b1;
			while (head < tail && cnt < MAX_RESULTS) begin
				cur = fifo[head];
				head++;
				hits[cnt] = cur;
				cnt++;
				for (i = 0; i < NODES; i++) begin
					if (adj_rows[cur][i] && !marks[i] && tail < NODES) begin
						marks[i] = 1'b1;
						fifo[tail] = NODE_ID_W'(i);
						tail++;
					end
				end
			end
		end else begin
			marks[start] = 1'b1;
			hits[0] = start;
			cnt = 1;
			stk_node[0] = start;
			stk_resume[0] = 0;
			depth = 1;
			while (depth > 0 && cnt < MAX_RESULTS) begin
				top = depth - 1;
				cur = stk_node[top];
				i = stk_resume[top];
				while (i < NODES && !(adj_rows[cur][i] && !marks[i]))
					i++;
				if (i >= NODES || depth >= NODES) begin
					depth--;
				end else begin
					stk_resume[top] = i + 1;
					marks[i] = 1'b1;
					hits[cnt] = NODE_ID_W'(i);
					cnt++;
					stk_node[depth] = NODE_ID_W'(i);
					stk_resume[depth] = 0;
					depth++;
				end
			end
		end
		for (i = 0; i < cnt; i++) begin
			r.visited_node = hits[i];
			r.last_visit = (i == cnt - 1);
			visit_queue.push_back(r);
		end
	endfunction

	function automatic void apply_item(input gtb_in_t item);
		if (item.node_id >= NODES)
			return;
		if (item.req_type == REQ_LOAD)
			adj_rows[item.node_id] = item.neighbor_bits;
		else
			predict_walk(item.node_id);
	endfunction

	function automatic logic [ROW_IN_W-1:0] random_row();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return ROW_IN_W'($urandom & $urandom & $urandom);
			3: return ROW_IN_W'($urandom & $urandom);
			4: return ROW_IN_W'($urandom);
			default: return ROW_IN_W'(1) << $urandom_range(0, NODES - 1);
		endcase
	endfunction

	// present one item and return at the edge that accepts it
	task automatic offer_item(input gtb_in_t item);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic end_phase();
		@(negedge clk);
		in_valid = 1'b0;
		while (visit_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_order(input logic val);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ORDER_ADDR;
		pwdata = PDATA_W'(val);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		walk_order = val;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (rd !== PDATA_W'(val))
			flag_mismatch($sformatf("order readback: expected %0h, got %0h", val, rd));
	endtask

	// mostly rows loaded then a walk, some lone walks and lone loads
	task automatic random_phase(input int n);
		gtb_in_t item;
		int      sent, loads, j;
		logic [NODE_ID_W-1:0] last_row;
		sent = 0;
		last_row = '0;
		while (sent < n) begin
			case ($urandom_range(0, 9))
				8: loads = 0;
				9: loads = -1;
				default: loads = $urandom_range(1, 4);
			endcase
			for (j = 0; j < ((loads < 0) ? 1 : loads); j++) begin
				item.req_type = REQ_LOAD;
				item.node_id = NODE_ID_W'($urandom_range(0, NODES - 1));
				item.neighbor_bits = random_row();
				last_row = item.node_id;
				offer_item(item);
				apply_item(item);
				sent++;
			end
			if (loads >= 0) begin
				item.req_type = REQ_START;
				item.node_id = $urandom_range(0, 1) ? last_row :
					NODE_ID_W'($urandom_range(0, NODES - 1));
				item.neighbor_bits = ROW_IN_W'($urandom);
				offer_item(item);
				apply_item(item);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			visits_taken++;
			if (visit_queue.size() == 0) begin
				flag_mismatch($sformatf("unexpected visit: node %0d last %0b",
					out_data.visited_node, out_data.last_visit));
			end else begin
				visit_want = visit_queue.pop_front();
				if (out_data.visited_node !== visit_want.visited_node ||
					out_data.last_visit !== visit_want.last_visit)
					flag_mismatch($sformatf("visit: expected node %0d last %0b, got node %0d last %0b",
						visit_want.visited_node, visit_want.last_visit,
						out_data.visited_node, out_data.last_visit));
			end
		end
	end

	initial begin : receiver
		int span, mode;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			// hold off once long enough for the block to back up into its input
			if (!pressure_done && visits_taken >= 30) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				pressure_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = $urandom_range(0, 1);
				endcase
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		walk_order = ORDER_BFS;
		for (k = 0; k < NODES; k++)
			adj_rows[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows run in breadth-first order, the reset setting
		for (k = 0; k < $size(directed_rows); k++) begin
			offer_item(directed_rows[k].item);
			if (directed_rows[k].typed)
				visit_queue.push_back({directed_rows[k].want, 1'b1});
			else
				apply_item(directed_rows[k].item);
		end
		end_phase();

		set_order(ORDER_DFS);
		random_phase(33);
		end_phase();
		set_order(ORDER_BFS);
		random_phase(33);
		end_phase();
		set_order(ORDER_DFS);
		random_phase(33);
		end_phase();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> files.f
+incdir+src
src/gtb_pkg.sv
src/gtb_ram.sv
src/gtb_ctrl.sv
src/gtb_dp.sv
src/graph_traversal_bfs_dfs.sv
test/graph_traversal_bfs_dfs_tb.sv
